@@ sv/cspbp_pkg.sv @@
package cspbp_pkg;

	// Field widths
	localparam int CODE_BITS   = 16;
	localparam int SYM_BITS    = 8;
	localparam int LEN_BITS    = 5;
	localparam int PEND_BITS   = 7;
	localparam int CNT_BITS    = 3;
	localparam int ACC_BITS    = PEND_BITS + CODE_BITS + SYM_BITS;
	localparam int NUM_OUT     = 3;
	localparam int NBYTE_BITS  = 2;

	// Longest code that is packed; longer lengths saturate
	localparam int MAX_CODE_BITS = 16;
	localparam int CODE_LIM = (MAX_CODE_BITS < CODE_BITS) ? MAX_CODE_BITS : CODE_BITS;

	typedef enum logic {
		OP_PAIR  = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	// One input beat as held in the input stage
	typedef struct packed {
		op_t                  op;
		logic [CODE_BITS-1:0] code;
		logic [SYM_BITS-1:0]  sym;
		logic [LEN_BITS-1:0]  len;
	} item_t;

	// Bytes that one item completes, handed to the output buffer
	typedef struct packed {
		logic [NUM_OUT*8-1:0]  bytes;
		logic [NBYTE_BITS-1:0] nbytes;
		logic                  flush;
	} pack_res_t;

endpackage

@@ sv/cspbp_pack.sv @@
module cspbp_pack (
	input  cspbp_pkg::item_t     item,
	input  logic [6:0]           pend_bits,
	input  logic [2:0]           pend_count,
	output cspbp_pkg::pack_res_t res,
	output logic [6:0]           next_bits,
	output logic [2:0]           next_count
);
	import cspbp_pkg::*;

	logic [LEN_BITS-1:0]  len;
	logic [CODE_BITS-1:0] code_m;
	logic [6:0]           pend_m;
	logic [LEN_BITS-1:0]  sym_sh;
	logic [LEN_BITS-1:0]  total;
	logic [ACC_BITS-1:0]  acc;
	logic [ACC_BITS-1:0]  rest;

	// Saturate the code length and keep only the code bits in use
	assign len    = (item.len > LEN_BITS'(CODE_LIM)) ? LEN_BITS'(CODE_LIM) : item.len;
	assign code_m = CODE_BITS'(~({(CODE_BITS+1){1'b1}} << len));
	assign pend_m = pend_bits & ~(7'h7F << pend_count);

	// Line up pending bits, code and symbol, earliest bit at the bottom
	assign sym_sh = {2'b00, pend_count} + len;
	assign total  = sym_sh + LEN_BITS'(SYM_BITS);
	assign acc    = {{(ACC_BITS-PEND_BITS){1'b0}}, pend_m}
	              | ({{(ACC_BITS-CODE_BITS){1'b0}}, item.code & code_m} << pend_count)
	              | ({{(ACC_BITS-SYM_BITS){1'b0}}, item.sym} << sym_sh);
	assign rest   = acc >> {total[4:3], 3'b000};

	// Select flush or pair result and the state left behind
	always_comb begin
		if (item.op == OP_FLUSH) begin
			res.bytes  = {{(NUM_OUT*8-8){1'b0}}, 1'b0, pend_m};
			res.nbytes = (pend_count != 3'd0) ? 2'd1 : 2'd0;
			res.flush  = 1'b1;
			next_bits  = 7'd0;
			next_count = 3'd0;
		end else begin
			res.bytes  = acc[NUM_OUT*8-1:0];
			res.nbytes = total[4:3];
			res.flush  = 1'b0;
			next_count = total[2:0];
			next_bits  = rest[6:0] & ~(7'h7F << total[2:0]);
		end
	end

endmodule

@@ sv/cspbp_obuf.sv @@
module cspbp_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  cspbp_pkg::pack_res_t res,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 last_of_run,
	output logic                 from_flush
);
	import cspbp_pkg::*;

	logic [NUM_OUT*8-1:0]  bytes_q;
	logic [NBYTE_BITS-1:0] left_q;
	logic                  flush_q;

	assign out_valid   = (left_q != 2'd0);
	assign out_byte    = bytes_q[7:0];
	assign last_of_run = (left_q == 2'd1);
	assign from_flush  = flush_q;
	assign free        = (left_q == 2'd0) || ((left_q == 2'd1) && out_ready);

	// Hold the count of bytes still to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 2'd0;
		end else if (load) begin
			left_q <= res.nbytes;
		end else if (out_valid && out_ready) begin
			left_q <= left_q - 2'd1;
		end
	end

	// Load a new run, or advance to the next byte on each taken beat
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			flush_q <= res.flush;
		end else if (out_valid && out_ready) begin
			bytes_q <= bytes_q >> 8;
		end
	end

endmodule

@@ sv/code_symbol_pair_bit_packer.sv @@
// Channel | Handshake            | Beat contents
// input   | in_valid / in_ready  | operation, code_value, symbol_byte, code_length
// output  | out_valid / out_ready | out_byte, last_of_run, from_flush
//
// An accepted item is registered in the input stage, then its bytes load into the
// output buffer once that is free, and the first byte comes from the output buffer.
// The output buffer sends one byte per cycle while out_ready is high; a pair completes
// up to three bytes, a flush at most one.
// Reset clears the pending bits, the input stage and the output buffer.
// A stall on the output holds the buffer; the input stage still takes one more item.
module code_symbol_pair_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [15:0] code_value,
	input  logic [7:0]  symbol_byte,
	input  logic [4:0]  code_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        from_flush
);
	import cspbp_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	logic [6:0] pend_bits_q;
	logic [2:0] pend_count_q;
	logic [6:0] next_bits;
	logic [2:0] next_count;
	pack_res_t  res;
	logic       ob_free;
	logic       pack_go;

	assign pack_go  = valid_s1 && ob_free;
	assign in_ready = !valid_s1 || pack_go;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the input beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{op: op_t'(operation), code: code_value, sym: symbol_byte,
			             len: code_length};
		end
	end

	// Advance the leftover bits as each item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q  <= 7'd0;
			pend_count_q <= 3'd0;
		end else if (pack_go) begin
			pend_bits_q  <= next_bits;
			pend_count_q <= next_count;
		end
	end

	cspbp_pack u_pack (
		.item       (item_s1),
		.pend_bits  (pend_bits_q),
		.pend_count (pend_count_q),
		.res        (res),
		.next_bits  (next_bits),
		.next_count (next_count)
	);

	cspbp_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (pack_go),
		.res         (res),
		.free        (ob_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.from_flush  (from_flush)
	);

	// Leftover bits above the count stay zero
	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_bits_q & (7'h7F << pend_count_q)) == 7'd0)
		else $error("pending bits above count not zero");

	// A flush leaves nothing pending
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pack_go && item_s1.op == OP_FLUSH) |=> (pend_count_q == 3'd0))
		else $error("flush left pending bits");

	// A flush byte is always the only byte of its run
	a_flush_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && from_flush) |-> last_of_run)
		else $error("flush byte not last of run");

	// With the output buffer empty the input side never stalls
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

@@ sim/tb_code_symbol_pair_bit_packer.sv @@
`timescale 1ns / 100ps

module tb_code_symbol_pair_bit_packer;
	import cspbp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 120;
	localparam int CALM_TAIL    = 30;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 20;

	// One packed byte as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       flush;
	} byte_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = 1'b0;
	logic [15:0] code_value = '0;
	logic [7:0]  symbol_byte = '0;
	logic [4:0]  code_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        from_flush;

	item_t      item_queue[$];
	byte_beat_t packed_bytes[$];

	// Leftover bits of the packer, earliest bit in bit 0
	logic [PEND_BITS-1:0] held_bits = '0;
	logic [CNT_BITS-1:0]  held_count = '0;

	int n_items = 0;
	int n_offered = 0;
	int n_accepted = 0;
	int n_errors = 0;
	int send_gap = 0;
	int stall_cycles = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;
	int cycle_count = 0;

	item_t      next_item;
	item_t      seen_item;
	byte_beat_t got_beat;

	code_symbol_pair_bit_packer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.code_value  (code_value),
		.symbol_byte (symbol_byte),
		.code_length (code_length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.from_flush  (from_flush)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		n_errors++;
	endtask

	function automatic void add_item(op_t op, logic [15:0] code, logic [7:0] sym,
		logic [4:0] len);
		item_t it;
		it.op   = op;
		it.code = code;
		it.sym  = sym;
		it.len  = len;
		item_queue.push_back(it);
	endfunction

	// Append one item to the bit stream and queue the bytes it completes
	function automatic void pack_item(item_t it);
		logic [31:0] acc;
		int unsigned len;
		int unsigned total;
		int unsigned nbytes;
		int unsigned k;
		byte_beat_t b;
		if (it.op == OP_FLUSH) begin
			// drop an empty flush; otherwise pad the partial byte with zeros
			if (held_count != 0) begin
				b.data  = {1'b0, held_bits & ((7'd1 << held_count) - 7'd1)};
				b.last  = 1'b1;
				b.flush = 1'b1;
				packed_bytes.push_back(b);
			end
			held_bits  = '0;
			held_count = '0;
		end else begin
			// saturate long code lengths
			len = (int'(it.len) > CODE_LIM) ? CODE_LIM : it.len;
			acc = 32'(held_bits & ((7'd1 << held_count) - 7'd1));
			acc |= (32'(it.code) & ((32'd1 << len) - 32'd1)) << held_count;
			acc |= 32'(it.sym) << (held_count + len);
			total  = held_count + len + SYM_BITS;
			nbytes = total / 8;
			for (k = 0; k < nbytes; k++) begin
				b.data  = acc[8*k +: 8];
				b.last  = (k + 1 == nbytes);
				b.flush = 1'b0;
				packed_bytes.push_back(b);
			end
			held_count = CNT_BITS'(total % 8);
			held_bits  = PEND_BITS'((acc >> (8 * nbytes)) & ((32'd1 << held_count) - 32'd1));
		end
	endfunction

	// Build the stimulus, run reset, wait for the drain and judge
	initial begin
		int i;
		int r;
		logic [4:0] len;

		// directed: empty flush, extreme lengths, padding, saturation
		add_item(OP_FLUSH, 16'hFFFF, 8'hFF, 5'd31);
		add_item(OP_PAIR,  16'hFFFF, 8'h00, 5'd0);
		add_item(OP_PAIR,  16'hFFFF, 8'hFF, 5'd16);
		add_item(OP_PAIR,  16'h0001, 8'hA5, 5'd1);
		add_item(OP_FLUSH, 16'h0000, 8'h00, 5'd0);
		add_item(OP_FLUSH, 16'h0000, 8'h00, 5'd0);
		add_item(OP_PAIR,  16'h007F, 8'hFF, 5'd7);
		add_item(OP_PAIR,  16'hFFFF, 8'hFF, 5'd16);
		add_item(OP_PAIR,  16'hABCD, 8'h5A, 5'd31);
		add_item(OP_PAIR,  16'h1234, 8'hC3, 5'd17);
		add_item(OP_PAIR,  16'h0000, 8'h00, 5'd16);
		add_item(OP_FLUSH, 16'hFFFF, 8'hFF, 5'd16);
		add_item(OP_PAIR,  16'h8001, 8'h3C, 5'd5);
		add_item(OP_PAIR,  16'hFFF8, 8'h81, 5'd3);
		add_item(OP_FLUSH, 16'h5555, 8'hAA, 5'd10);
		add_item(OP_PAIR,  16'h5555, 8'hAA, 5'd8);
		add_item(OP_PAIR,  16'hAAAA, 8'h55, 5'd15);
		add_item(OP_PAIR,  16'h0000, 8'hFF, 5'd0);
		add_item(OP_FLUSH, 16'h0000, 8'h00, 5'd0);
		add_item(OP_PAIR,  16'hFFFF, 8'h00, 5'd24);
		add_item(OP_FLUSH, 16'h0000, 8'h00, 5'd0);

		// random: runs of pairs broken by the odd flush
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 9);
			len = (r == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
			add_item(($urandom_range(0, 7) == 0) ? OP_FLUSH : OP_PAIR,
				16'($urandom), 8'($urandom), len);
		end
		n_items = item_queue.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (item_queue.size() != 0 || in_valid || packed_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Offer the next item once the current beat is taken, with idle bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (item_queue.size() != 0) begin
				next_item = item_queue.pop_front();
				in_valid    <= 1'b1;
				operation   <= next_item.op;
				code_value  <= next_item.code;
				symbol_byte <= next_item.sym;
				code_length <= next_item.len;
				n_offered   <= n_offered + 1;
				if (n_offered + 1 < n_items - CALM_TAIL && $urandom_range(0, 3) == 0)
					send_gap <= $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive out_ready: one long hold mid-run, random stall bursts before the tail
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready   <= 1'b0;
		end else if (!hold_done && n_accepted >= 50) begin
			hold_done   <= 1'b1;
			hold_cycles <= LONG_HOLD;
			out_ready   <= 1'b0;
		end else if (stall_cycles != 0) begin
			stall_cycles <= stall_cycles - 1;
			out_ready    <= 1'b0;
		end else if (n_offered < n_items - CALM_TAIL && $urandom_range(0, 4) == 0) begin
			stall_cycles <= $urandom_range(0, 9);
			out_ready    <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Predict on every accepted item, then check every accepted byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen_item.op   = op_t'(operation);
				seen_item.code = code_value;
				seen_item.sym  = symbol_byte;
				seen_item.len  = code_length;
				pack_item(seen_item);
				n_accepted <= n_accepted + 1;
			end
			if (out_valid && out_ready) begin
				if (packed_bytes.size() == 0) begin
					report_error($sformatf("unexpected beat byte=%h last=%b flush=%b",
						out_byte, last_of_run, from_flush));
				end else begin
					got_beat = packed_bytes.pop_front();
					if (out_byte !== got_beat.data || last_of_run !== got_beat.last ||
						from_flush !== got_beat.flush)
						report_error($sformatf(
							"byte=%h last=%b flush=%b, expected byte=%h last=%b flush=%b",
							out_byte, last_of_run, from_flush,
							got_beat.data, got_beat.last, got_beat.flush));
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
				packed_bytes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
